@@ design/array_list_engine_unit_defines.svh @@
// Assertion macros for the array list engine modules.
`ifndef ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH
`define ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ALE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define ALE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ale_pkg.sv @@
package ale_pkg;

  localparam int unsigned PosW = 7;
  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_LOCATE = 3'd3,
    OP_PRIOR  = 3'd4,
    OP_NEXT   = 3'd5,
    OP_CLEAR  = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_NONEIGH  = 3'd4
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load;      // capture the request word
    logic            rd_en;     // read memory at rd_addr
    logic [PosW-1:0] rd_addr;
    logic            wr_en;     // write memory
    logic [PosW-1:0] wr_addr;
    logic            wr_sel_val; // 1: write request value, 0: write read data
    logic            cnt_inc;
    logic            cnt_dec;
    logic            cnt_clr;
    logic            prev_save; // remember last read word as previous entry
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t             op;
    logic [PosW-1:0] pos;
    logic [PosW-1:0] count;
    logic            match;     // read data equals request value
  } dp_stat_t;

endpackage

@@ design/ale_datapath.sv @@
module ale_datapath #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ale_pkg::dp_cmd_t              cmd,
  input  logic [2:0]                    operation,
  input  logic [ale_pkg::PosW-1:0]      position,
  input  logic signed [ale_pkg::DataW-1:0] value,
  output ale_pkg::dp_stat_t             stat,
  output logic [ale_pkg::DataW-1:0]     rd_data,
  output logic [ale_pkg::DataW-1:0]     prev_data
);
  import ale_pkg::*;

  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [DataW-1:0] mem [CAPACITY];
  op_t              op;
  logic [PosW-1:0]  pos;
  logic [DataW-1:0] val;
  logic [PosW-1:0]  count;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= op_t'(operation);
      pos <= position;
      val <= value;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_addr[AddrW-1:0]];
    end
    if (cmd.prev_save) begin
      prev_data <= rd_data;
    end
    if (cmd.wr_en) begin
      mem[cmd.wr_addr[AddrW-1:0]] <= cmd.wr_sel_val ? val : rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_clr) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + PosW'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - PosW'(1);
    end
  end

  assign stat.op    = op;
  assign stat.pos   = pos;
  assign stat.count = count;
  assign stat.match = (rd_data == val);
endmodule

@@ design/ale_control.sv @@
`include "array_list_engine_unit_defines.svh"

module ale_control #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  ale_pkg::dp_stat_t             stat,
  input  logic [ale_pkg::DataW-1:0]     rd_data,
  input  logic [ale_pkg::DataW-1:0]     prev_data,
  output ale_pkg::dp_cmd_t              cmd,
  output logic                          strobe,
  output logic [2:0]                    status,
  output logic [ale_pkg::PosW-1:0]      found_position,
  output logic [ale_pkg::DataW-1:0]     data,
  output logic [ale_pkg::PosW-1:0]      list_length,
  output logic                          last
);
  import ale_pkg::*;

  localparam logic [PosW-1:0] Cap = PosW'(CAPACITY);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_SHUP   = 7'b0000100, // insert: read i-1, write i, walking down
    S_SHDN   = 7'b0001000, // delete: read i, write i-1, walking up
    S_GET    = 7'b0010000,
    S_SCAN   = 7'b0100000, // search: one entry read per cycle
    S_FIN    = 7'b1000000
  } state_t;

  state_t          state, state_next;
  logic [PosW-1:0] idx, idx_next;     // entry index under work
  logic            hit, hit_next;     // any match seen so far
  logic            pend, pend_next;   // a match word or an insert's value waits
  logic [PosW-1:0] ppos, ppos_next;   // position of that pending match
  logic [DataW-1:0] held, held_next;  // data of the pending match word
  logic [DataW-1:0] pdata;            // pending data as of this cycle
  logic            o_stb;
  logic [2:0]      o_st;
  logic [PosW-1:0] o_pos;
  logic [DataW-1:0] o_data;
  logic            o_last;
  logic            o_ldone;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      hit    <= 1'b0;
      pend   <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= o_stb;
      hit    <= hit_next;
      pend   <= pend_next;
    end
    idx  <= idx_next;
    ppos <= ppos_next;
    held <= held_next;
    if (o_stb) begin
      status         <= o_st;
      found_position <= o_pos;
      data           <= o_data;
      last           <= o_last;
    end
  end

  // The length reported is the count after the request's update.
  assign list_length = stat.count;
  assign busy = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    hit_next    = hit;
    pend_next   = pend;
    ppos_next   = ppos;
    held_next   = held;
    pdata       = held;
    cmd         = '0;
    o_stb       = 1'b0;
    o_st        = ST_OK;
    o_pos       = '0;
    o_data      = '0;
    o_last      = 1'b0;
    o_ldone     = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        hit_next  = 1'b0;
        pend_next = 1'b0;
        case (stat.op)
          OP_INSERT: begin
            if (stat.pos == '0 || stat.pos > stat.count + PosW'(1)) begin
              o_stb = 1'b1; o_st = ST_BADPOS; o_last = 1'b1;
              state_next = S_FIN;
            end else if (stat.count >= Cap) begin
              o_stb = 1'b1; o_st = ST_FULL; o_last = 1'b1;
              state_next = S_FIN;
            end else if (stat.count == stat.pos - PosW'(1)) begin
              cmd.wr_en = 1'b1; cmd.wr_addr = stat.pos - PosW'(1);
              cmd.wr_sel_val = 1'b1; cmd.cnt_inc = 1'b1;
              o_stb = 1'b1; o_pos = stat.pos; o_last = 1'b1;
              state_next = S_FIN;
            end else begin
              cmd.rd_en = 1'b1; cmd.rd_addr = stat.count - PosW'(1);
              idx_next = stat.count;
              state_next = S_SHUP;
            end
          end
          OP_DELETE, OP_GET: begin
            if (stat.pos == '0 || stat.pos > stat.count) begin
              o_stb = 1'b1; o_st = ST_BADPOS; o_last = 1'b1;
              state_next = S_FIN;
            end else begin
              cmd.rd_en = 1'b1; cmd.rd_addr = stat.pos - PosW'(1);
              state_next = S_GET;
            end
          end
          OP_LOCATE, OP_PRIOR, OP_NEXT: begin
            if (stat.count == '0) begin
              o_stb = 1'b1; o_st = ST_NOTFOUND; o_last = 1'b1;
              state_next = S_FIN;
            end else begin
              cmd.rd_en = 1'b1; cmd.rd_addr = '0;
              idx_next = PosW'(1);
              state_next = S_SCAN;
            end
          end
          OP_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            o_stb = 1'b1; o_last = 1'b1;
            state_next = S_FIN;
          end
          default: begin
            o_stb = 1'b1; o_last = 1'b1;
            state_next = S_FIN;
          end
        endcase
      end
      S_SHUP: begin
        // rd_data is entry idx-1; move it to idx.
        cmd.wr_en = 1'b1; cmd.wr_addr = idx;
        if (idx - PosW'(1) == stat.pos - PosW'(1)) begin
          state_next = S_FIN;
          o_ldone = 1'b1;
        end else begin
          cmd.rd_en = 1'b1; cmd.rd_addr = idx - PosW'(2);
          idx_next = idx - PosW'(1);
        end
        if (o_ldone) begin
          // The slot is free; the shifted word is written this cycle, the
          // new value lands in the final cycle below.
          idx_next = idx - PosW'(1);
          state_next = S_FIN;
          pend_next = 1'b1;
        end
      end
      S_GET: begin
        o_stb = 1'b1; o_pos = stat.pos; o_data = rd_data; o_last = 1'b1;
        if (stat.op == OP_DELETE) begin
          cmd.cnt_dec = 1'b1;
          if (stat.pos < stat.count) begin
            cmd.rd_en = 1'b1; cmd.rd_addr = stat.pos;
            idx_next = stat.pos;
            state_next = S_SHDN;
          end else begin
            state_next = S_FIN;
          end
        end else begin
          state_next = S_FIN;
        end
      end
      S_SHDN: begin
        // rd_data is entry idx; the count is already one lower.
        cmd.wr_en = 1'b1; cmd.wr_addr = idx - PosW'(1);
        if (idx >= stat.count) begin
          state_next = S_FIN;
        end else begin
          cmd.rd_en = 1'b1; cmd.rd_addr = idx + PosW'(1);
          idx_next = idx + PosW'(1);
        end
      end
      S_SCAN: begin
        // rd_data holds entry idx-1; prev_data holds entry idx-2.
        // Each match word is held back until the next match or the end of
        // the walk, so that the final word can carry last.
        cmd.prev_save = 1'b1;
        if (stat.op == OP_NEXT && ppos == idx - PosW'(1)) begin
          // The pending match was the previous entry; this one is its next.
          pdata = rd_data;
        end
        held_next = pdata;
        if (stat.match) begin
          hit_next = 1'b1;
          if (pend) begin
            o_stb = 1'b1; o_pos = ppos; o_data = pdata;
            if (stat.op == OP_PRIOR && ppos == PosW'(1)) begin
              o_st = ST_NONEIGH;
            end
          end
          pend_next = 1'b1; ppos_next = idx;
          if (stat.op == OP_LOCATE) begin
            held_next = rd_data;
          end else if (stat.op == OP_PRIOR && idx != PosW'(1)) begin
            held_next = prev_data;
          end else begin
            held_next = '0;
          end
        end
        if (idx >= stat.count) begin
          if (!stat.match && !hit) begin
            o_stb = 1'b1; o_st = ST_NOTFOUND; o_pos = '0; o_data = '0;
            o_last = 1'b1;
          end
          state_next = S_FIN;
        end else begin
          cmd.rd_en = 1'b1; cmd.rd_addr = idx;
          idx_next = idx + PosW'(1);
        end
      end
      S_FIN: begin
        if (pend && stat.op == OP_INSERT) begin
          cmd.wr_en = 1'b1; cmd.wr_addr = stat.pos - PosW'(1);
          cmd.wr_sel_val = 1'b1; cmd.cnt_inc = 1'b1;
          o_stb = 1'b1; o_pos = stat.pos; o_last = 1'b1;
        end else if (pend) begin
          // The last match of a search; the first entry has no prior and
          // the last entry has no next.
          o_stb = 1'b1; o_pos = ppos; o_data = held; o_last = 1'b1;
          if ((stat.op == OP_PRIOR && ppos == PosW'(1)) ||
              (stat.op == OP_NEXT && ppos == stat.count)) begin
            o_st = ST_NONEIGH;
          end
        end
        pend_next  = 1'b0;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `ALE_ASSERT_IMP(a_stb_busy, clk, rst, strobe && last, state == S_IDLE || state == S_FIN || state == S_SHDN, "final word in an unexpected state")
  `ALE_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "accepted request did not raise busy")
  `ALE_ASSERT_IMP(a_len_cap, clk, rst, 1'b1, stat.count <= Cap, "length above capacity")
  `ALE_ASSERT_IMP(a_onehot, clk, rst, 1'b1, $onehot(state), "state not one-hot")
endmodule

@@ design/array_list_engine_unit.sv @@
// Channel   Ports                                        Handshake
// request   operation, position, value                   start high while busy low
// result    status, found_position, data, list_length,   strobe, one cycle each
//           last
//
// A request is taken at a clock edge with start high and busy low; busy
// then stays high until the request is done, so the next one waits. Insert
// and delete move entries one at a time, since the store has a single read
// and a single write port. Locate, prior and next read one entry per cycle.
// The final word of a search with a match is shown in the first cycle with
// busy low; a search with no match shows it while busy is still high. A
// delete shows its word first and then keeps busy high while it moves entries.
// Synchronous reset empties the list; the store itself is not cleared.
// The receiver cannot stall: each word is marked by strobe for one cycle only.
module array_list_engine_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    operation,
  input  logic [ale_pkg::PosW-1:0]      position,
  input  logic signed [ale_pkg::DataW-1:0] value,
  output logic                          strobe,
  output logic [2:0]                    status,
  output logic [ale_pkg::PosW-1:0]      found_position,
  output logic signed [ale_pkg::DataW-1:0] data,
  output logic [ale_pkg::PosW-1:0]      list_length,
  output logic                          last
);
  import ale_pkg::*;

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [DataW-1:0] rd_data;
  logic [DataW-1:0] prev_data;
  logic [DataW-1:0] data_u;

  // The datapath holds the store, the request word and the length.
  ale_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .operation(operation),
    .position(position), .value(value), .stat(stat),
    .rd_data(rd_data), .prev_data(prev_data)
  );

  // The controller sequences the walk and registers each result word.
  ale_control #(.CAPACITY(CAPACITY)) u_ctl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .stat(stat),
    .rd_data(rd_data), .prev_data(prev_data), .cmd(cmd),
    .strobe(strobe), .status(status), .found_position(found_position),
    .data(data_u), .list_length(list_length), .last(last)
  );

  assign data = signed'(data_u);
endmodule

@@ tb/sv/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ale_pkg::*;

  localparam int unsigned Capacity = 64;

  // One pending request word as the driver applies it.
  typedef struct {
    logic [2:0]      op;
    logic [PosW-1:0] pos;
    logic [31:0]     val;
  } req_word_t;

  // One expected result word.
  typedef struct {
    logic [2:0]      st;
    logic [PosW-1:0] fpos;
    logic [31:0]     dat;
    logic [PosW-1:0] len;
    logic            lst;
  } res_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] operation = '0;
  logic [PosW-1:0] position = '0;
  logic signed [DataW-1:0] value = '0;
  logic strobe;
  logic [2:0] status;
  logic [PosW-1:0] found_position;
  logic signed [DataW-1:0] data;
  logic [PosW-1:0] list_length;
  logic last;

  array_list_engine_unit #(.CAPACITY(Capacity)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .position(position), .value(value),
    .strobe(strobe), .status(status), .found_position(found_position),
    .data(data), .list_length(list_length), .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The testbench's own picture of the list contents.
  logic [31:0] list_mem [Capacity];
  int unsigned list_cnt = 0;

  req_word_t pending_reqs[$];
  res_word_t expected_words[$];
  int unsigned mismatches = 0;
  int unsigned idle_pct = 0;
  int unsigned sent = 0;

  // Busy as sampled at the last rising edge, so the driver knows whether the
  // word it held was taken.
  logic busy_at_edge = 1'b1;

  // Append one expected word; list_length reflects the list after the request.
  task automatic push_word(logic [2:0] st, int unsigned fpos, logic [31:0] dat);
    res_word_t w;
    w.st = st; w.fpos = fpos[PosW-1:0]; w.dat = dat;
    w.len = list_cnt[PosW-1:0]; w.lst = 1'b0;
    expected_words.push_back(w);
  endtask

  // Apply one request to the list picture and queue the words it produces.
  task automatic predict_list_op(req_word_t r);
    int unsigned p;
    int unsigned hits;
    logic [31:0] removed;
    p = r.pos;
    hits = 0;
    case (r.op)
      OP_INSERT: begin
        if (p < 1 || p > list_cnt + 1) push_word(ST_BADPOS, 0, '0);
        else if (list_cnt >= Capacity) push_word(ST_FULL, 0, '0);
        else begin
          for (int i = list_cnt; i > p - 1; i--) list_mem[i] = list_mem[i-1];
          list_mem[p-1] = r.val;
          list_cnt++;
          push_word(ST_OK, p, '0);
        end
      end
      OP_DELETE: begin
        if (p < 1 || p > list_cnt) push_word(ST_BADPOS, 0, '0);
        else begin
          removed = list_mem[p-1];
          for (int i = p; i < list_cnt; i++) list_mem[i-1] = list_mem[i];
          list_cnt--;
          push_word(ST_OK, p, removed);
        end
      end
      OP_GET: begin
        if (p < 1 || p > list_cnt) push_word(ST_BADPOS, 0, '0);
        else push_word(ST_OK, p, list_mem[p-1]);
      end
      OP_LOCATE, OP_PRIOR, OP_NEXT: begin
        for (int i = 0; i < list_cnt; i++) begin
          if (list_mem[i] == r.val) begin
            hits++;
            if (r.op == OP_LOCATE) push_word(ST_OK, i + 1, list_mem[i]);
            else if (r.op == OP_PRIOR) begin
              if (i == 0) push_word(ST_NONEIGH, 1, '0);
              else push_word(ST_OK, i + 1, list_mem[i-1]);
            end else begin
              if (i + 1 == list_cnt) push_word(ST_NONEIGH, i + 1, '0);
              else push_word(ST_OK, i + 1, list_mem[i+1]);
            end
          end
        end
        if (hits == 0) push_word(ST_NOTFOUND, 0, '0);
      end
      OP_CLEAR: begin
        list_cnt = 0;
        push_word(ST_OK, 0, '0);
      end
      default: push_word(ST_OK, 0, '0);
    endcase
    expected_words[$].lst = 1'b1;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    mismatches++;
  endtask

  // Driver: presents the head of the pending queue at the falling edge and
  // drops it once an edge has seen start high with busy low.
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !busy_at_edge) begin
        void'(pending_reqs.pop_front());
        sent++;
      end
      if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        operation <= pending_reqs[0].op;
        position <= pending_reqs[0].pos;
        value <= pending_reqs[0].val;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    busy_at_edge <= busy;
    // Prediction happens when the word is accepted, so queue order matches.
    if (!rst && start && !busy) predict_list_op(pending_reqs[0]);
  end

  // Monitor: every strobe is one result word.
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_words.size() == 0) begin
        $display("result word with nothing expected");
        mismatches++;
      end else begin
        res_word_t w;
        w = expected_words.pop_front();
        if (status !== w.st) report_mismatch("status", 32'(status), 32'(w.st));
        if (found_position !== w.fpos)
          report_mismatch("found_position", 32'(found_position), 32'(w.fpos));
        if (data !== w.dat) report_mismatch("data", data, w.dat);
        if (list_length !== w.len)
          report_mismatch("list_length", 32'(list_length), 32'(w.len));
        if (last !== w.lst) report_mismatch("last", 32'(last), 32'(w.lst));
      end
    end
  end

  // Values drawn from a small pool give repeated matches for the searches.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'h8000_0000 | $urandom_range(3);
      default: return $urandom_range(5);
    endcase
  endfunction

  function automatic req_word_t make_req(logic [2:0] op, int unsigned p, logic [31:0] v);
    req_word_t r;
    r.op = op; r.pos = p[PosW-1:0]; r.val = v;
    return r;
  endfunction

  // Random request biased toward valid positions around the current length.
  task automatic queue_random(int unsigned len_hint);
    int unsigned k;
    int unsigned p;
    k = $urandom_range(99);
    if ($urandom_range(9) == 0) p = $urandom_range(127);
    else p = $urandom_range(len_hint + 1);
    if (k < 40) pending_reqs.push_back(make_req(OP_INSERT, p, pick_value()));
    else if (k < 55) pending_reqs.push_back(make_req(OP_DELETE, p, $urandom));
    else if (k < 67) pending_reqs.push_back(make_req(OP_GET, p, $urandom));
    else if (k < 76) pending_reqs.push_back(make_req(OP_LOCATE, p, pick_value()));
    else if (k < 85) pending_reqs.push_back(make_req(OP_PRIOR, p, pick_value()));
    else if (k < 94) pending_reqs.push_back(make_req(OP_NEXT, p, pick_value()));
    else if (k < 97) pending_reqs.push_back(make_req(OP_CLEAR, p, $urandom));
    else pending_reqs.push_back(make_req(OP_NONE, p, $urandom));
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_words.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned target;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-list cases, both ends, a full list, rejected positions.
    pending_reqs.push_back(make_req(OP_GET, 1, '0));
    pending_reqs.push_back(make_req(OP_DELETE, 0, '0));
    pending_reqs.push_back(make_req(OP_LOCATE, 0, '0));
    pending_reqs.push_back(make_req(OP_INSERT, 0, 32'h1));
    pending_reqs.push_back(make_req(OP_INSERT, 2, 32'h1));
    pending_reqs.push_back(make_req(OP_INSERT, 1, 32'h7FFF_FFFF));
    pending_reqs.push_back(make_req(OP_INSERT, 1, 32'h8000_0000));
    pending_reqs.push_back(make_req(OP_INSERT, 3, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(OP_PRIOR, 0, 32'h8000_0000));
    pending_reqs.push_back(make_req(OP_NEXT, 0, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(OP_PRIOR, 0, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(OP_NEXT, 0, 32'h8000_0000));
    pending_reqs.push_back(make_req(OP_GET, 3, '0));
    pending_reqs.push_back(make_req(OP_GET, 4, '0));
    pending_reqs.push_back(make_req(OP_DELETE, 127, '0));
    pending_reqs.push_back(make_req(OP_DELETE, 2, '0));
    pending_reqs.push_back(make_req(OP_NONE, 127, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(OP_CLEAR, 0, '0));
    // Fill to capacity with one repeated value so searches return 64 words.
    for (int i = 1; i <= Capacity; i++) pending_reqs.push_back(make_req(OP_INSERT, i, 32'h5));
    pending_reqs.push_back(make_req(OP_INSERT, 1, 32'h6));
    pending_reqs.push_back(make_req(OP_INSERT, 66, 32'h6));
    pending_reqs.push_back(make_req(OP_LOCATE, 0, 32'h5));
    pending_reqs.push_back(make_req(OP_NEXT, 0, 32'h5));
    pending_reqs.push_back(make_req(OP_DELETE, 64, '0));
    pending_reqs.push_back(make_req(OP_CLEAR, 0, '0));
    drain();

    // Three random phases with different sender idle rates.
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 8 : (ph == 1) ? 72 : 0;
      target = sent + 130;
      while (sent < target) begin
        if (pending_reqs.size() < 2) queue_random(list_cnt);
        @(posedge clk);
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/ale_pkg.sv
design/ale_datapath.sv
design/ale_control.sv
design/array_list_engine_unit.sv
tb/sv/tb.sv
